>>> sv/sdfe_pkg.sv
// Shared types, character codes and the per-byte line parser for the SSE data extractor.
package sdfe_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] NAME_LEN = 3'd4;

	typedef enum logic [2:0] {
		PH_START       = 3'd0,
		PH_NAME        = 3'd1,
		PH_VALUE_FIRST = 3'd2,
		PH_VALUE       = 3'd3,
		PH_SKIP        = 3'd4
	} phase_t;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       event_end;
		logic       last_of_step;
	} result_t;

	// Parser state that travels through the byte handler
	typedef struct packed {
		phase_t     phase;
		logic [2:0] match_cnt;
		logic       mismatch;
		logic       has_data;
	} line_state_t;

	typedef struct packed {
		line_state_t st;
		logic        vld;
		result_t     res;
	} byte_out_t;

	// Letters of the field name "data"
	function automatic logic [7:0] name_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h64;
			2'd1: c = 8'h61;
			2'd2: c = 8'h74;
			default: c = 8'h61;
		endcase
		return c;
	endfunction

	// Handle one line byte; a CR reaching here is an ordinary byte
	function automatic byte_out_t plain_byte(input line_state_t s, input logic [7:0] b);
		byte_out_t r;
		r.st  = s;
		r.vld = 1'b0;
		r.res = '{data_byte: 8'h00, event_end: 1'b0, last_of_step: 1'b0};
		if (b == CH_LF) begin
			if (s.phase == PH_START) begin
				if (s.has_data) begin
					r.vld           = 1'b1;
					r.res.event_end = 1'b1;
				end
				r.st.has_data = 1'b0;
			end
			r.st.phase     = PH_START;
			r.st.match_cnt = 3'd0;
			r.st.mismatch  = 1'b0;
		end else begin
			unique case (s.phase)
				PH_START, PH_NAME: begin
					if (b == CH_COLON) begin
						if (s.phase == PH_START) begin
							r.st.phase = PH_SKIP;
						end else if (!s.mismatch && s.match_cnt == NAME_LEN) begin
							if (s.has_data) begin
								r.vld           = 1'b1;
								r.res.data_byte = CH_LF;
							end
							r.st.phase = PH_VALUE_FIRST;
						end else begin
							r.st.phase = PH_SKIP;
						end
					end else begin
						if (!s.mismatch && s.match_cnt < NAME_LEN &&
						    b == name_char(s.match_cnt[1:0]))
							r.st.match_cnt = s.match_cnt + 3'd1;
						else
							r.st.mismatch = 1'b1;
						r.st.phase = PH_NAME;
					end
				end
				PH_VALUE_FIRST: begin
					r.st.phase = PH_VALUE;
					if (b != CH_SPACE) begin
						r.vld           = 1'b1;
						r.res.data_byte = b;
						r.st.has_data   = 1'b1;
					end
				end
				PH_VALUE: begin
					r.vld           = 1'b1;
					r.res.data_byte = b;
					r.st.has_data   = 1'b1;
				end
				default: begin
					r.st.phase = PH_SKIP;
				end
			endcase
		end
		return r;
	endfunction

endpackage

>>> sv/sse_data_field_extractor_top.sv
// Top level of the SSE data extractor: input register, step logic and result queue.
//
// Usage:
//   The item channel carries one stream byte (opcode 0) or a flush (opcode 1)
//   per transaction. The result channel carries one payload byte or an event
//   end marker per transaction; last_of_step flags the final result of an item.
//   Both channels move a transaction when valid is high and stall is low.
// Path: an item taken into the input register is worked by the step logic,
//   and its results are written into the result queue once the queue has
//   room for two; a result reaches the result port from the queue head.
// Throughput: one item per cycle. An item yields 0 to 2 results and the
//   result port drains one per cycle, so items that yield two results
//   (a held CR as payload, then a payload byte or end marker) let the four-entry
//   result queue fill; the item side then stalls until it has room for two.
// Reset: arst_n clears the parser to line start with no event open, no CR
//   held and an empty result queue.
// Stall: while result_stall is high the queue holds its head; items keep
//   being taken until the queue cannot take two more results.
module sse_data_field_extractor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sdfe_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output sdfe_pkg::result_t   result
);

	localparam int QDEPTH = 4;

	// input register
	logic                  valid_s1;
	sdfe_pkg::item_t       item_s1;

	// parser state
	sdfe_pkg::line_state_t st_q;
	logic                  held_cr_q;

	// result queue
	sdfe_pkg::result_t     q_mem_q [QDEPTH];
	logic [1:0]            head_q;
	logic [2:0]            cnt_q;

	sdfe_pkg::line_state_t st_nxt;
	logic                  held_cr_nxt;
	logic [1:0]            res_cnt;
	sdfe_pkg::result_t     res0, res1;
	logic                  pop, proc;
	logic [1:0]            wr_idx;

	sdfe_step u_step (
		.st          (st_q),
		.held_cr     (held_cr_q),
		.item        (item_s1),
		.st_nxt      (st_nxt),
		.held_cr_nxt (held_cr_nxt),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	assign result_valid = (cnt_q != 3'd0);
	assign result       = q_mem_q[head_q];
	assign pop          = result_valid && !result_stall;

	// advance the registered item only when the queue can take two results
	assign proc       = valid_s1 && ((cnt_q - {2'd0, pop}) <= 3'd2);
	assign item_stall = valid_s1 && !proc;
	assign wr_idx     = head_q + cnt_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			st_q      <= '{phase: sdfe_pkg::PH_START, match_cnt: 3'd0,
			               mismatch: 1'b0, has_data: 1'b0};
			held_cr_q <= 1'b0;
			head_q    <= 2'd0;
			cnt_q     <= 3'd0;
		end else begin
			// load a new item whenever the stage is free or drains this cycle
			if (!valid_s1 || proc)
				valid_s1 <= item_valid;
			if (proc) begin
				st_q      <= st_nxt;
				held_cr_q <= held_cr_nxt;
			end
			if (pop)
				head_q <= head_q + 2'd1;
			cnt_q <= cnt_q - {2'd0, pop} + (proc ? {1'b0, res_cnt} : 3'd0);
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
		if (proc && res_cnt != 2'd0)
			q_mem_q[wr_idx] <= res0;
		if (proc && res_cnt == 2'd2)
			q_mem_q[wr_idx + 2'd1] <= res1;
	end

endmodule

>>> sv/sdfe_step.sv
// Combinational per-item step: held-CR handling, flush and up to two results.
module sdfe_step (
	input  sdfe_pkg::line_state_t st,
	input  logic                  held_cr,
	input  sdfe_pkg::item_t       item,
	output sdfe_pkg::line_state_t st_nxt,
	output logic                  held_cr_nxt,
	output logic [1:0]            res_cnt,
	output sdfe_pkg::result_t     res0,
	output sdfe_pkg::result_t     res1
);

	sdfe_pkg::byte_out_t   a, b;
	sdfe_pkg::line_state_t st_a;
	logic                  use_a, use_b;
	sdfe_pkg::result_t     end_res;
	logic                  end_vld;
	logic                  is_flush;

	assign is_flush = (item.opcode == sdfe_pkg::OP_FLUSH);

	always_comb begin
		// first handler call: the held CR, or the new byte itself
		use_a = 1'b0;
		a     = sdfe_pkg::plain_byte(st, sdfe_pkg::CH_CR);
		if (held_cr) begin
			use_a = 1'b1;
			if (!is_flush && item.rx_byte == sdfe_pkg::CH_LF)
				a = sdfe_pkg::plain_byte(st, sdfe_pkg::CH_LF);
		end else if (!is_flush && item.rx_byte != sdfe_pkg::CH_CR) begin
			use_a = 1'b1;
			a     = sdfe_pkg::plain_byte(st, item.rx_byte);
		end
		st_a = use_a ? a.st : st;

		// second call: a byte following a held CR that was not LF or CR
		use_b = held_cr && !is_flush && item.rx_byte != sdfe_pkg::CH_LF &&
		        item.rx_byte != sdfe_pkg::CH_CR;
		b     = sdfe_pkg::plain_byte(st_a, item.rx_byte);

		held_cr_nxt = !is_flush && item.rx_byte == sdfe_pkg::CH_CR;

		end_vld = 1'b0;
		end_res = '{data_byte: 8'h00, event_end: 1'b1, last_of_step: 1'b0};
		if (is_flush) begin
			end_vld            = st_a.has_data;
			st_nxt             = st_a;
			st_nxt.has_data    = 1'b0;
			st_nxt.phase       = sdfe_pkg::PH_START;
			st_nxt.match_cnt   = 3'd0;
			st_nxt.mismatch    = 1'b0;
		end else if (use_b) begin
			st_nxt = b.st;
		end else begin
			st_nxt = st_a;
		end

		// pack the results into the lowest slots and mark the last one
		res0    = a.res;
		res1    = use_b ? b.res : end_res;
		res_cnt = 2'd0;
		if (use_a && a.vld) begin
			res_cnt = 2'd1;
			if ((use_b && b.vld) || end_vld)
				res_cnt = 2'd2;
		end else if (use_b && b.vld) begin
			res0    = b.res;
			res_cnt = 2'd1;
		end else if (end_vld) begin
			res0    = end_res;
			res_cnt = 2'd1;
		end
		res0.last_of_step = (res_cnt == 2'd1);
		res1.last_of_step = 1'b1;
	end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the SSE data field extractor.
`timescale 1ns / 100ps

module testbench;

	localparam string FIELD_NAME = "data";

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	sdfe_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b1;
	sdfe_pkg::result_t result;

	sse_data_field_extractor_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Stream items waiting to be driven, and the payload bytes and end
	// markers that the parser should produce from accepted items, oldest first.
	sdfe_pkg::item_t   pending_items[$];
	sdfe_pkg::result_t predicted_stream[$];
	sdfe_pkg::result_t step_out[$];

	int errors      = 0;
	int items_taken = 0;
	int hold_left   = 0;
	int holds_done  = 0;
	int send_gap    = 0;
	int stall_left  = 0;
	bit tx_quiet    = 1'b0;
	bit rx_quiet    = 1'b0;

	string other_names[6] = '{"event", "id", "retry", "dat", "datas", "Data"};

	// Parser state of the predictor
	sdfe_pkg::phase_t cur_phase       = sdfe_pkg::PH_START;
	logic [2:0]       name_hits       = 3'd0;
	logic             name_bad        = 1'b0;
	logic             evt_has_payload = 1'b0;
	logic             cr_held         = 1'b0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	task send_payload(input logic [7:0] b);
		if (step_out.size() < 2)
			step_out.push_back('{data_byte: b, event_end: 1'b0, last_of_step: 1'b0});
		evt_has_payload = 1'b1;
	endtask

	// Emit the end marker only when the event carried some payload
	task close_event();
		if (evt_has_payload && step_out.size() < 2)
			step_out.push_back('{data_byte: 8'h00, event_end: 1'b1, last_of_step: 1'b0});
		evt_has_payload = 1'b0;
	endtask

	task restart_line();
		cur_phase = sdfe_pkg::PH_START;
		name_hits = 3'd0;
		name_bad  = 1'b0;
	endtask

	// One byte of a line; a CR arriving here counts as an ordinary byte
	task line_byte(input logic [7:0] b);
		if (b == sdfe_pkg::CH_LF) begin
			// a blank line closes the event
			if (cur_phase == sdfe_pkg::PH_START)
				close_event();
			restart_line();
			return;
		end
		case (cur_phase)
			sdfe_pkg::PH_START, sdfe_pkg::PH_NAME: begin
				if (b == sdfe_pkg::CH_COLON) begin
					if (cur_phase == sdfe_pkg::PH_START) begin
						cur_phase = sdfe_pkg::PH_SKIP;
					end else if (!name_bad && name_hits == sdfe_pkg::NAME_LEN) begin
						// separator before each later data line of the event
						if (evt_has_payload)
							send_payload(sdfe_pkg::CH_LF);
						cur_phase = sdfe_pkg::PH_VALUE_FIRST;
					end else begin
						cur_phase = sdfe_pkg::PH_SKIP;
					end
				end else begin
					if (!name_bad && name_hits < sdfe_pkg::NAME_LEN &&
					    b == FIELD_NAME[name_hits])
						name_hits = name_hits + 3'd1;
					else
						name_bad = 1'b1;
					cur_phase = sdfe_pkg::PH_NAME;
				end
			end
			sdfe_pkg::PH_VALUE_FIRST: begin
				// drop one space right after the colon
				cur_phase = sdfe_pkg::PH_VALUE;
				if (b != sdfe_pkg::CH_SPACE)
					send_payload(b);
			end
			sdfe_pkg::PH_VALUE: begin
				send_payload(b);
			end
			default: begin
				cur_phase = sdfe_pkg::PH_SKIP;
			end
		endcase
	endtask

	// Work out the results of one accepted item and queue them
	task predict_item(input sdfe_pkg::item_t it);
		sdfe_pkg::result_t r;
		step_out.delete();
		if (it.opcode == sdfe_pkg::OP_FLUSH) begin
			if (cr_held) begin
				cr_held = 1'b0;
				line_byte(sdfe_pkg::CH_CR);
			end
			close_event();
			restart_line();
		end else if (cr_held) begin
			// a held CR that is not followed by LF is a line byte
			cr_held = 1'b0;
			if (it.rx_byte == sdfe_pkg::CH_LF) begin
				line_byte(it.rx_byte);
			end else begin
				line_byte(sdfe_pkg::CH_CR);
				if (it.rx_byte == sdfe_pkg::CH_CR)
					cr_held = 1'b1;
				else
					line_byte(it.rx_byte);
			end
		end else if (it.rx_byte == sdfe_pkg::CH_CR) begin
			cr_held = 1'b1;
		end else begin
			line_byte(it.rx_byte);
		end
		foreach (step_out[k]) begin
			r              = step_out[k];
			r.last_of_step = (k == step_out.size() - 1);
			predicted_stream.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly zero, sometimes a few cycles, now and then a long pause
	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task push_byte(input logic [7:0] b);
		sdfe_pkg::item_t it;
		it.opcode  = sdfe_pkg::OP_BYTE;
		it.rx_byte = b;
		pending_items.push_back(it);
	endtask

	task push_flush();
		sdfe_pkg::item_t it;
		it.opcode  = sdfe_pkg::OP_FLUSH;
		it.rx_byte = 8'($urandom_range(0, 255));
		pending_items.push_back(it);
	endtask

	task push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] payload_byte();
		if ($urandom_range(0, 9) == 0)
			return sdfe_pkg::CH_CR;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] noise_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return sdfe_pkg::CH_LF;
		if (r < 30)
			return sdfe_pkg::CH_CR;
		if (r < 45)
			return sdfe_pkg::CH_COLON;
		if (r < 55)
			return sdfe_pkg::CH_SPACE;
		if (r < 75)
			return FIELD_NAME[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	// One event of one to four lines, ended by a blank line or a flush; a few
	// are plain noise instead
	task add_random_event();
		int n;
		int kind;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				if ($urandom_range(0, 15) == 0)
					push_flush();
				else
					push_byte(noise_byte());
			end
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				push_text("data:");
				if ($urandom_range(0, 1))
					push_byte(sdfe_pkg::CH_SPACE);
				n = $urandom_range(0, 8);
				repeat (n) push_byte(payload_byte());
			end else if (kind < 65) begin
				push_byte(sdfe_pkg::CH_COLON);
				n = $urandom_range(0, 5);
				repeat (n) push_byte(payload_byte());
			end else if (kind < 78) begin
				push_text(other_names[$urandom_range(0, 5)]);
				push_byte(sdfe_pkg::CH_COLON);
				n = $urandom_range(0, 5);
				repeat (n) push_byte(payload_byte());
			end else if (kind < 88) begin
				n = $urandom_range(1, 6);
				repeat (n) push_byte(FIELD_NAME[$urandom_range(0, 3)]);
			end else begin
				// cut a data line short; what follows parses as a new line
				push_text("data:");
				n = $urandom_range(0, 4);
				repeat (n) push_byte(payload_byte());
				push_flush();
			end
			if ($urandom_range(0, 3) == 0)
				push_byte(sdfe_pkg::CH_CR);
			push_byte(sdfe_pkg::CH_LF);
		end
		case ($urandom_range(0, 3))
			0: begin
				push_flush();
			end
			1: begin
				push_byte(sdfe_pkg::CH_CR);
				push_byte(sdfe_pkg::CH_LF);
			end
			default: begin
				push_byte(sdfe_pkg::CH_LF);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued items, predict on every accepted transaction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_item(item);
				items_taken <= items_taken + 1;
			end
			// advance only when nothing is on offer or the offer was taken
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
					if ($urandom_range(0, 49) == 0)
						tx_quiet = !tx_quiet;
					// keep offering back to back while the receiver holds off
					send_gap = (tx_quiet || hold_left != 0) ? 0 : idle_len();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold-offs, so the result queue fills and the item side
	// stalls while the driver keeps offering
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && items_taken >= 100) ||
		             (holds_done == 1 && items_taken >= 400)) begin
			hold_left  <= $urandom_range(150, 300);
			holds_done <= holds_done + 1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each accepted result with the oldest prediction.
	// A result leaves the block only after its item was taken and stepped
	// into the result queue, so its prediction is always queued by then.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		sdfe_pkg::result_t want;
		if (!arst_n) begin
			result_stall <= 1'b1;
		end else begin
			if (result_valid && !result_stall) begin
				if (predicted_stream.size() == 0) begin
					$error("unexpected result: data_byte %h event_end %b last_of_step %b",
					       result.data_byte, result.event_end, result.last_of_step);
					errors++;
				end else begin
					want = predicted_stream.pop_front();
					if (result.data_byte !== want.data_byte) begin
						$error("data_byte: expected %h, got %h", want.data_byte,
						       result.data_byte);
						errors++;
					end
					if (result.event_end !== want.event_end) begin
						$error("event_end: expected %b, got %b", want.event_end,
						       result.event_end);
						errors++;
					end
					if (result.last_of_step !== want.last_of_step) begin
						$error("last_of_step: expected %b, got %b", want.last_of_step,
						       result.last_of_step);
						errors++;
					end
				end
			end
			// stall pattern for the next cycle
			if (hold_left != 0) begin
				result_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if ($urandom_range(0, 99) == 0)
					rx_quiet = !rx_quiet;
				stall_left = rx_quiet ? 0 : idle_len();
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: build stimulus, reset, wait for the stream to drain
	// ------------------------------------------------------------------
	initial begin
		int directed_count;
		int drain_cycles;

		// empty data value then flush: nothing opens, nothing closes
		push_text("data:");
		push_flush();
		// field name longer than "data": ignored
		push_text("datas");
		push_byte(sdfe_pkg::CH_LF);
		// extreme bytes, lone CR, CR after CR
		push_text("data:");
		push_byte(8'h00);
		push_byte(sdfe_pkg::CH_CR);
		push_byte(sdfe_pkg::CH_CR);
		push_byte(8'hFF);
		push_byte(sdfe_pkg::CH_LF);
		// separator, skipped space, flush with a CR held
		push_text("data: ");
		push_byte(sdfe_pkg::CH_CR);
		push_flush();

		directed_count = pending_items.size();
		while (pending_items.size() < directed_count + 600)
			add_random_event();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_valid)
			@(posedge clk);
		drain_cycles = 0;
		while (predicted_stream.size() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		// let any stray result show up
		repeat (8) @(posedge clk);

		if (predicted_stream.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_stream.size());
			errors++;
		end
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
